[hdl/acesftm_pkg.sv]
// ----------------------------------------------------------------------------
// acesftm_pkg
// Shared types, widths, register codes and reset values of the ACES filmic
// tone mapper.
// ----------------------------------------------------------------------------
package acesftm_pkg;

  // fixed field widths
  localparam int unsigned IW = 24;  // input channel word
  localparam int unsigned CW = 16;  // coefficient word
  localparam int unsigned QW = 8;   // display byte

  localparam int unsigned IN_FRAC_BITS_DEF = 16;

  // configuration register codes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_E = 3'd4;

  localparam logic [CW-1:0] COEF_A_RST = 16'd10281;
  localparam logic [CW-1:0] COEF_B_RST = 16'd123;
  localparam logic [CW-1:0] COEF_C_RST = 16'd9953;
  localparam logic [CW-1:0] COEF_D_RST = 16'd2417;
  localparam logic [CW-1:0] COEF_E_RST = 16'd573;

  // pipeline stage numbering
  localparam int unsigned ST_SQR     = 0;  // x*x, b*x, d*x
  localparam int unsigned ST_PART    = 1;  // coefficient partial products
  localparam int unsigned ST_PROD    = 2;  // partial products joined
  localparam int unsigned ST_SUM     = 3;  // numerator and denominator
  localparam int unsigned ST_PREP    = 4;  // flags, 255*num
  localparam int unsigned ST_DIV0    = 5;  // first quotient bit
  localparam int unsigned NUM_STAGES = ST_DIV0 + QW;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  typedef struct packed {
    logic [CW-1:0] a;
    logic [CW-1:0] b;
    logic [CW-1:0] c;
    logic [CW-1:0] d;
    logic [CW-1:0] e;
  } coef_t;

  // width of numerator / denominator sums at the common scale
  function automatic int unsigned sum_width(int unsigned frac_bits);
    int unsigned w;
    w = CW + 2 * IW;
    if (CW + IW + frac_bits > w) w = CW + IW + frac_bits;
    if (CW + 2 * frac_bits > w) w = CW + 2 * frac_bits;
    return w + 2;
  endfunction

endpackage

[hdl/acesftm_regs.sv]
// ----------------------------------------------------------------------------
// acesftm_regs
// Curve coefficient registers with write decode.
// ----------------------------------------------------------------------------
module acesftm_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [acesftm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [acesftm_pkg::CW-1:0]          cfg_data_i,
  output acesftm_pkg::coef_t                  coef_o
);
  import acesftm_pkg::*;

  coef_t coef_d, coef_q;

  always_comb begin
    coef_d = coef_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_COEF_A: coef_d.a = cfg_data_i;
        REG_COEF_B: coef_d.b = cfg_data_i;
        REG_COEF_C: coef_d.c = cfg_data_i;
        REG_COEF_D: coef_d.d = cfg_data_i;
        REG_COEF_E: coef_d.e = cfg_data_i;
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.a <= COEF_A_RST;
      coef_q.b <= COEF_B_RST;
      coef_q.c <= COEF_C_RST;
      coef_q.d <= COEF_D_RST;
      coef_q.e <= COEF_E_RST;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

[hdl/acesftm_poly.sv]
// ----------------------------------------------------------------------------
// acesftm_poly
// Four-stage pipeline forming numerator x(ax+b) and denominator x(cx+d)+e
// of one channel at the common scale 2^(2F+COEF_FRAC).
// ----------------------------------------------------------------------------
module acesftm_poly #(
  parameter int unsigned IN_FRAC_BITS = acesftm_pkg::IN_FRAC_BITS_DEF
) (
  input  logic                                             clk_i,
  input  acesftm_pkg::stage_en_t                           en_i,
  input  acesftm_pkg::coef_t                               coef_i,
  input  logic [acesftm_pkg::IW-1:0]                       x_i,
  output logic [acesftm_pkg::sum_width(IN_FRAC_BITS)-1:0]  num_o,
  output logic [acesftm_pkg::sum_width(IN_FRAC_BITS)-1:0]  den_o
);
  import acesftm_pkg::*;

  localparam int unsigned SW  = sum_width(IN_FRAC_BITS);
  localparam int unsigned X2W = 2 * IW;
  localparam int unsigned LW  = CW + IW;
  localparam int unsigned PW  = CW + 2 * IW;

  logic [X2W-1:0] x2_q;
  logic [LW-1:0]  bx_q, dx_q, bx2_q, dx2_q, bx3_q, dx3_q;
  logic [LW-1:0]  pah_q, pal_q, pch_q, pcl_q;
  logic [PW-1:0]  pa_q, pc_q;
  logic [SW-1:0]  num_q, den_q;

  always_ff @(posedge clk_i) begin
    if (en_i[ST_SQR]) begin
      x2_q <= X2W'(x_i) * X2W'(x_i);
      bx_q <= LW'(coef_i.b) * LW'(x_i);
      dx_q <= LW'(coef_i.d) * LW'(x_i);
    end
  end

  // x*x split in halves keeps each product at 16 x 24
  always_ff @(posedge clk_i) begin
    if (en_i[ST_PART]) begin
      pah_q <= LW'(coef_i.a) * LW'(x2_q[X2W-1:IW]);
      pal_q <= LW'(coef_i.a) * LW'(x2_q[IW-1:0]);
      pch_q <= LW'(coef_i.c) * LW'(x2_q[X2W-1:IW]);
      pcl_q <= LW'(coef_i.c) * LW'(x2_q[IW-1:0]);
      bx2_q <= bx_q;
      dx2_q <= dx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_PROD]) begin
      pa_q  <= (PW'(pah_q) << IW) + PW'(pal_q);
      pc_q  <= (PW'(pch_q) << IW) + PW'(pcl_q);
      bx3_q <= bx2_q;
      dx3_q <= dx2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_SUM]) begin
      num_q <= SW'(pa_q) + (SW'(bx3_q) << IN_FRAC_BITS);
      den_q <= SW'(pc_q) + (SW'(dx3_q) << IN_FRAC_BITS)
             + (SW'(coef_i.e) << (2 * IN_FRAC_BITS));
    end
  end

  assign num_o = num_q;
  assign den_o = den_q;

endmodule

[hdl/acesftm_div.sv]
// ----------------------------------------------------------------------------
// acesftm_div
// Clamp and byte quotient floor(255*num/den): one preparation stage, then
// one restoring-division stage per quotient bit.
// ----------------------------------------------------------------------------
module acesftm_div #(
  parameter int unsigned IN_FRAC_BITS = acesftm_pkg::IN_FRAC_BITS_DEF
) (
  input  logic                                             clk_i,
  input  acesftm_pkg::stage_en_t                           en_i,
  input  logic [acesftm_pkg::sum_width(IN_FRAC_BITS)-1:0]  num_i,
  input  logic [acesftm_pkg::sum_width(IN_FRAC_BITS)-1:0]  den_i,
  output logic [acesftm_pkg::QW-1:0]                       byte_o
);
  import acesftm_pkg::*;

  localparam int unsigned SW = sum_width(IN_FRAC_BITS);
  localparam int unsigned RW = SW + QW;

  logic [RW-1:0] rem_q  [QW];
  logic [SW-1:0] den_q  [QW];
  logic          zero_q [QW+1];
  logic          sat_q  [QW+1];
  logic [QW-1:0] quo_q  [QW+1];

  // 255*num as (num << 8) - num
  always_ff @(posedge clk_i) begin
    if (en_i[ST_PREP]) begin
      zero_q[0] <= (den_i == '0);
      sat_q[0]  <= (num_i >= den_i);
      rem_q[0]  <= (RW'(num_i) << QW) - RW'(num_i);
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_bit
    localparam int unsigned K = QW - 1 - j;
    logic [RW-1:0] trial;
    logic          take;

    assign trial = RW'(den_q[j]) << K;
    assign take  = (rem_q[j] >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i[ST_DIV0 + j]) begin
        zero_q[j+1] <= zero_q[j];
        sat_q[j+1]  <= sat_q[j];
        quo_q[j+1]  <= quo_q[j] | (QW'(take) << K);
      end
    end

    if (j < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i[ST_DIV0 + j]) begin
          rem_q[j+1] <= take ? (rem_q[j] - trial) : rem_q[j];
          den_q[j+1] <= den_q[j];
        end
      end
    end
  end

  // zero denominator wins over saturation
  assign byte_o = zero_q[QW] ? '0 : (sat_q[QW] ? '1 : quo_q[QW]);

endmodule

[hdl/aces_filmic_tone_mapper.sv]
// ----------------------------------------------------------------------------
// aces_filmic_tone_mapper
// ACES filmic curve x(ax+b)/(x(cx+d)+e) on three Q8.16 channels, clamped to
// [0,1] and truncated to display bytes.
// ----------------------------------------------------------------------------
// One pixel is taken per clock while in_stall_o is low and then passes
// through 13 register stages: four stages of multiply and add
// build the exact numerator and denominator, one stage forms the clamp flags
// and 255*num, and eight restoring-division stages each settle one quotient
// bit. Every stage holds a valid bit and
// only moves when the stage after it is empty or moving, so bubbles are
// squeezed out and input is stalled only when the whole pipe is full and
// the output is stalled. Coefficients are written through the cfg port
// (always ready) and should only change while no pixel is in flight.
module aces_filmic_tone_mapper #(
  parameter int unsigned IN_FRAC_BITS = acesftm_pkg::IN_FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [acesftm_pkg::IW-1:0]         red_in_i,
  input  logic [acesftm_pkg::IW-1:0]         green_in_i,
  input  logic [acesftm_pkg::IW-1:0]         blue_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [acesftm_pkg::QW-1:0]         red_out_o,
  output logic [acesftm_pkg::QW-1:0]         green_out_o,
  output logic [acesftm_pkg::QW-1:0]         blue_out_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [acesftm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [acesftm_pkg::CW-1:0]         cfg_data_i
);
  import acesftm_pkg::*;

  localparam int unsigned SW = sum_width(IN_FRAC_BITS);

  coef_t     coef;
  stage_en_t en;
  logic [NUM_STAGES-1:0] vld_q;

  logic [IW-1:0] chan_in  [3];
  logic [QW-1:0] chan_out [3];

  assign cfg_ready_o = 1'b1;

  acesftm_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef)
  );

  // a stage may load when it is empty or its content moves on
  always_comb begin
    en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || !out_stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[NUM_STAGES-1];

  assign chan_in[0] = red_in_i;
  assign chan_in[1] = green_in_i;
  assign chan_in[2] = blue_in_i;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [SW-1:0] num, den;

    acesftm_poly #(
      .IN_FRAC_BITS (IN_FRAC_BITS)
    ) u_poly (
      .clk_i  (clk_i),
      .en_i   (en),
      .coef_i (coef),
      .x_i    (chan_in[c]),
      .num_o  (num),
      .den_o  (den)
    );

    acesftm_div #(
      .IN_FRAC_BITS (IN_FRAC_BITS)
    ) u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (num),
      .den_i  (den),
      .byte_o (chan_out[c])
    );
  end

  assign red_out_o   = chan_out[0];
  assign green_out_o = chan_out[1];
  assign blue_out_o  = chan_out[2];

endmodule

[hdl/acesftm_checker.sv]
// ----------------------------------------------------------------------------
// acesftm_checker
// Port-level checks of the tone mapper, bound to the top level.
// ----------------------------------------------------------------------------
module acesftm_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic [acesftm_pkg::IW-1:0]         red_in_i,
  input logic [acesftm_pkg::IW-1:0]         green_in_i,
  input logic [acesftm_pkg::IW-1:0]         blue_in_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [acesftm_pkg::QW-1:0]         red_out_o,
  input logic [acesftm_pkg::QW-1:0]         green_out_o,
  input logic [acesftm_pkg::QW-1:0]         blue_out_o,
  input logic                               cfg_valid_i,
  input logic                               cfg_ready_o,
  input logic [acesftm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [acesftm_pkg::CW-1:0]         cfg_data_i
);

  // input back-pressure only when the output transaction is itself stalled
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output free");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(red_out_o) && $stable(green_out_o)
       && $stable(blue_out_o)))
    else $error("stalled result changed or dropped");

  // a stalled input transaction is held by the sender
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=>
      (in_valid_i && $stable(red_in_i) && $stable(green_in_i)
       && $stable(blue_in_i)))
    else $error("stalled input changed or dropped");

  a_cfg_known : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> !$isunknown({cfg_index_i, cfg_data_i}))
    else $error("config write carries unknown bits");

  a_cfg_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind aces_filmic_tone_mapper acesftm_checker u_checker (.*);

[bench/aces_filmic_tone_mapper_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aces_filmic_tone_mapper_tb
// Self-checking bench for the ACES filmic tone mapper. Pixels are predicted
// with exact wide-integer arithmetic from a local copy of the coefficients
// and compared in order against every output transaction. The run starts
// with directed extremes, then repeats random pixel phases over several
// coefficient settings and idle/stall mixes.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [acesftm_pkg::QW-1:0] red;
  logic [acesftm_pkg::QW-1:0] green;
  logic [acesftm_pkg::QW-1:0] blue;
} display_px_t;

class tone_scoreboard;
  acesftm_pkg::coef_t coefs;
  display_px_t        expected_px[$];
  int unsigned        mismatches;

  function new();
    coefs.a    = acesftm_pkg::COEF_A_RST;
    coefs.b    = acesftm_pkg::COEF_B_RST;
    coefs.c    = acesftm_pkg::COEF_C_RST;
    coefs.d    = acesftm_pkg::COEF_D_RST;
    coefs.e    = acesftm_pkg::COEF_E_RST;
    mismatches = 0;
  endfunction

  function void load_coef(logic [acesftm_pkg::CFG_IDX_W-1:0] idx,
                          logic [acesftm_pkg::CW-1:0] val);
    case (idx)
      acesftm_pkg::REG_COEF_A: coefs.a = val;
      acesftm_pkg::REG_COEF_B: coefs.b = val;
      acesftm_pkg::REG_COEF_C: coefs.c = val;
      acesftm_pkg::REG_COEF_D: coefs.d = val;
      acesftm_pkg::REG_COEF_E: coefs.e = val;
      default: ;
    endcase
  endfunction

  // numerator and denominator at scale 2^(2*frac+coef_frac), exact
  function logic [acesftm_pkg::QW-1:0] tone_curve(logic [acesftm_pkg::IW-1:0] x);
    bit [95:0] xw, ca, cb, cc, cd, ce, num, den;
    xw  = x;
    ca  = coefs.a;
    cb  = coefs.b;
    cc  = coefs.c;
    cd  = coefs.d;
    ce  = coefs.e;
    num = ca * xw * xw + ((cb * xw) << acesftm_pkg::IN_FRAC_BITS_DEF);
    den = cc * xw * xw + ((cd * xw) << acesftm_pkg::IN_FRAC_BITS_DEF)
        + (ce << (2 * acesftm_pkg::IN_FRAC_BITS_DEF));
    if (den == 0) return '0;
    if (num >= den) return '1;
    return acesftm_pkg::QW'((num * 255) / den);
  endfunction

  function void note_pixel(logic [acesftm_pkg::IW-1:0] r, g, b);
    display_px_t px;
    px.red   = tone_curve(r);
    px.green = tone_curve(g);
    px.blue  = tone_curve(b);
    expected_px.push_back(px);
  endfunction

  function void compare_byte(string chan, logic [acesftm_pkg::QW-1:0] want, got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, chan, want, got);
      mismatches++;
    end
  endfunction

  function void check_pixel(display_px_t got);
    display_px_t want;
    if (expected_px.size() == 0) begin
      $display("%0t: output pixel expected none actual %h", $time, got);
      mismatches++;
      return;
    end
    want = expected_px.pop_front();
    compare_byte("red_out", want.red, got.red);
    compare_byte("green_out", want.green, got.green);
    compare_byte("blue_out", want.blue, got.blue);
  endfunction
endclass

module aces_filmic_tone_mapper_tb;
  import acesftm_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES    = 20;
  localparam int unsigned NUM_PHASES       = 8;
  localparam int unsigned PIXELS_PER_PHASE = 116;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [IW-1:0]        red_in    = '0;
  logic [IW-1:0]        green_in  = '0;
  logic [IW-1:0]        blue_in   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [QW-1:0]        red_out;
  logic [QW-1:0]        green_out;
  logic [QW-1:0]        blue_out;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0]        cfg_data  = '0;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;

  tone_scoreboard sb = new();

  always #5 clk = ~clk;

  aces_filmic_tone_mapper i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .red_in_i    (red_in),
    .green_in_i  (green_in),
    .blue_in_i   (blue_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .red_out_o   (red_out),
    .green_out_o (green_out),
    .blue_out_o  (blue_out),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // transaction monitors
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.load_coef(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_pixel(red_in, green_in, blue_in);
      if (out_valid && !out_stall) sb.check_pixel({red_out, green_out, blue_out});
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic [IW-1:0] r, g, b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    red_in   <= r;
    green_in <= g;
    blue_in  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (sb.expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly the useful range below 16.0, with some full-scale words
  function automatic logic [IW-1:0] rand_radiance();
    case ($urandom_range(9))
      0, 1:       return IW'($urandom_range(255));
      2, 3, 4, 5: return IW'($urandom_range(24'h0FFFFF));
      6: begin
        case ($urandom_range(2))
          0:       return '0;
          1:       return '1;
          default: return IW'(1) << IN_FRAC_BITS_DEF;
        endcase
      end
      default:    return IW'($urandom);
    endcase
  endfunction

  function automatic logic [CW-1:0] rand_coef();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic program_coefs(input int unsigned phase);
    logic [CW-1:0] va, vb, vc, vd, ve;
    int unsigned   k;
    va = rand_coef();
    vb = rand_coef();
    vc = rand_coef();
    vd = rand_coef();
    ve = rand_coef();
    case (phase)
      0: begin
        va = '1; vb = '1; vc = '1; vd = '1; ve = '1;
      end
      1: begin
        va = '0; vb = '0; vc = '0; vd = '0; ve = '0;
      end
      2: begin
        va = COEF_A_RST; vb = COEF_B_RST; vc = COEF_C_RST;
        vd = COEF_D_RST; ve = COEF_E_RST;
      end
      3: ve = '0;   // black input gives a zero denominator
      4: begin
        va = '1; vc = '0;   // numerator outruns denominator: saturation
      end
      default: ;
    endcase
    write_reg(REG_COEF_A, va);
    write_reg(REG_COEF_B, vb);
    write_reg(REG_COEF_C, vc);
    write_reg(REG_COEF_D, vd);
    write_reg(REG_COEF_E, ve);
    // indexes past coef_e must leave the coefficients alone
    for (k = REG_COEF_E + 1; k < 2 ** CFG_IDX_W; k++) begin
      write_reg(CFG_IDX_W'(k), CW'($urandom));
    end
  endtask

  initial begin
    int unsigned phase, k;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pixels on reset coefficients
    send_pixel('0, '0, '0);
    send_pixel('1, '1, '1);
    send_pixel(24'h010000, 24'h008000, 24'h020000);
    send_pixel(24'h000001, 24'hFFFFFF, 24'h000000);
    send_pixel(24'h00FFFF, 24'h010001, 24'h0A0000);
    send_pixel(24'h555555, 24'hAAAAAA, 24'h7FFFFF);
    send_pixel(24'h800000, 24'h000100, 24'h0000FF);
    for (k = 0; k < 8; k++) begin
      send_pixel(IW'(1) << k, IW'(1) << (k + 8), IW'(1) << (k + 16));
    end
    settle_pipeline();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      program_coefs(phase);
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 84; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 84; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      send_pixel('0, '1, '0);
      send_pixel('1, '0, '1);
      for (k = 0; k < PIXELS_PER_PHASE; k++) begin
        send_pixel(rand_radiance(), rand_radiance(), rand_radiance());
      end
      settle_pipeline();
    end

    if (sb.mismatches == 0 && sb.expected_px.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
hdl/acesftm_pkg.sv
hdl/acesftm_regs.sv
hdl/acesftm_poly.sv
hdl/acesftm_div.sv
hdl/aces_filmic_tone_mapper.sv
hdl/acesftm_checker.sv
bench/aces_filmic_tone_mapper_tb.sv
